### rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU policy package
// Shared sizes, chain record and update command types for the LFU policy table.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES    = 16;
    localparam int USE_BITS   = 16;
    localparam int STAMP_BITS = 32;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W      = $clog2(ENTRIES + 1);
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int CAP_W      = 5;

    localparam logic [USE_BITS-1:0] USE_MAX = {USE_BITS{1'b1}};

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // Search record handed from cell to cell during a scan
    typedef struct packed {
        logic                  valid;
        logic [KEY_W-1:0]      key;
        logic [STAMP_BITS-1:0] clk;
        logic                  found;
        logic [IDX_W-1:0]      found_idx;
        logic [VAL_W-1:0]      found_val;
        logic                  vic_ok;
        logic [IDX_W-1:0]      vic_idx;
        logic [USE_BITS-1:0]   vic_uses;
        logic [STAMP_BITS-1:0] vic_age;
        logic [KEY_W-1:0]      vic_key;
        logic                  free_ok;
        logic [IDX_W-1:0]      free_idx;
    } carry_t;

    // Update command broadcast to all cells at the end of a transaction
    typedef struct packed {
        logic                  touch_en;
        logic                  set_val;
        logic [IDX_W-1:0]      touch_idx;
        logic                  evict_en;
        logic [IDX_W-1:0]      evict_idx;
        logic                  ins_en;
        logic [IDX_W-1:0]      ins_idx;
        logic [KEY_W-1:0]      key;
        logic [VAL_W-1:0]      value;
        logic [STAMP_BITS-1:0] clk;
    } upd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

endpackage

### rtl/lfu_cell.sv
// ----------------------------------------------------------------------------
// LFU table cell
// Holds one entry, folds it into the passing search record and applies updates.
// ----------------------------------------------------------------------------
module lfu_cell
    import lfu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  carry_t           carry_in,
    output carry_t           carry_out,
    input  upd_t             upd
);

    logic                  valid_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VAL_W-1:0]      value_reg;
    logic [USE_BITS-1:0]   uses_reg;
    logic [STAMP_BITS-1:0] stamp_reg;
    carry_t                carry_reg;
    carry_t                carry_next;
    logic [STAMP_BITS-1:0] age;

    assign age       = carry_in.clk - stamp_reg;
    assign carry_out = carry_reg;

    always_comb
    begin
        carry_next = carry_in;
        if (carry_in.valid && valid_reg)
        begin
            if (!carry_in.found && key_reg == carry_in.key)
            begin
                carry_next.found     = 1'b1;
                carry_next.found_idx = cell_idx;
                carry_next.found_val = value_reg;
            end
            if (!carry_in.vic_ok || uses_reg < carry_in.vic_uses ||
                (uses_reg == carry_in.vic_uses && age > carry_in.vic_age))
            begin
                carry_next.vic_ok   = 1'b1;
                carry_next.vic_idx  = cell_idx;
                carry_next.vic_uses = uses_reg;
                carry_next.vic_age  = age;
                carry_next.vic_key  = key_reg;
            end
        end
        if (carry_in.valid && !valid_reg && !carry_in.free_ok)
        begin
            carry_next.free_ok  = 1'b1;
            carry_next.free_idx = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            carry_reg <= carry_next;
            // an insert into the victim's own slot keeps it valid
            if (upd.ins_en && upd.ins_idx == cell_idx)
                valid_reg <= 1'b1;
            else if (upd.evict_en && upd.evict_idx == cell_idx)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.ins_en && upd.ins_idx == cell_idx)
        begin
            key_reg   <= upd.key;
            value_reg <= upd.value;
            uses_reg  <= USE_BITS'(1);
            stamp_reg <= upd.clk;
        end
        else if (upd.touch_en && upd.touch_idx == cell_idx)
        begin
            if (upd.set_val)
                value_reg <= upd.value;
            if (uses_reg != USE_MAX)
                uses_reg <= uses_reg + USE_BITS'(1);
            stamp_reg <= upd.clk;
        end
    end

endmodule

### rtl/lfu_cache_policy_core.sv
// ----------------------------------------------------------------------------
// LFU cache policy core
// LFU key/value table with oldest-access tie break, built as a chain of cells.
// ----------------------------------------------------------------------------
// The search record walks the cell chain one cell per cycle, then fin_reg captures it,
// the apply state applies it and the result is registered; a new transaction is
// accepted only in the idle state, after the previous one has been applied.
// A stalled result holds the next apply cycle until it is taken.
// Reset: asynchronous, active low; clears all entries, occupancy and access clock,
// and sets capacity to 16.
module lfu_cache_policy_core
    import lfu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,   // key[31:0], write_value[63:32]
    input  logic [0:0]       s_tuser,   // mode[0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,   // hit[0], read_value[32:1], evicted[33],
                                        // evicted_key[65:34], zero[71:66]
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    state_t                state_reg, state_next;
    logic [CAP_W-1:0]      capacity_reg;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [STAMP_BITS-1:0] clock_reg, clock_next;
    logic                  mode_reg;
    logic [VAL_W-1:0]      wval_reg;
    carry_t                fin_reg;
    logic                  out_valid_reg;
    logic [71:0]           out_data_reg, out_data_next;
    carry_t                link [ENTRIES+1];
    upd_t                  upd;
    logic                  accept, capture, fire;
    logic [OCC_W-1:0]      cap_eff;
    logic                  is_put, cap_on, evict_do, ins_ok;
    logic [IDX_W-1:0]      ins_idx;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        link[0]       = '0;
        link[0].valid = accept;
        link[0].key   = s_tdata[31:0];
        link[0].clk   = clock_reg;
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            lfu_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (IDX_W'(g)),
                .carry_in (link[g]),
                .carry_out(link[g+1]),
                .upd      (upd)
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        capture    = 1'b0;
        fire       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (link[ENTRIES].valid)
                begin
                    capture    = 1'b1;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    fire       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Decide the update from the finished search record
    always_comb
    begin
        if (32'(capacity_reg) > 32'(ENTRIES))
            cap_eff = OCC_W'(ENTRIES);
        else
            cap_eff = OCC_W'(capacity_reg);
        is_put   = (mode_reg == MODE_PUT);
        cap_on   = (cap_eff != '0);
        evict_do = is_put && cap_on && !fin_reg.found && occ_reg >= cap_eff && fin_reg.vic_ok;
        if (evict_do)
        begin
            ins_ok  = 1'b1;
            ins_idx = (fin_reg.free_ok && fin_reg.free_idx < fin_reg.vic_idx) ?
                      fin_reg.free_idx : fin_reg.vic_idx;
        end
        else
        begin
            ins_ok  = fin_reg.free_ok;
            ins_idx = fin_reg.free_idx;
        end

        upd           = '0;
        upd.touch_en  = fire && fin_reg.found && (!is_put || cap_on);
        upd.set_val   = is_put;
        upd.touch_idx = fin_reg.found_idx;
        upd.evict_en  = fire && evict_do;
        upd.evict_idx = fin_reg.vic_idx;
        upd.ins_en    = fire && is_put && cap_on && !fin_reg.found && ins_ok;
        upd.ins_idx   = ins_idx;
        upd.key       = fin_reg.key;
        upd.value     = wval_reg;
        upd.clk       = clock_reg;

        occ_next = occ_reg;
        if (upd.evict_en && occ_reg != '0)
            occ_next = occ_reg - OCC_W'(1);
        if (upd.ins_en && occ_next < OCC_W'(ENTRIES))
            occ_next = occ_next + OCC_W'(1);

        clock_next = clock_reg;
        if (upd.touch_en || upd.ins_en)
            clock_next = clock_reg + STAMP_BITS'(1);

        out_data_next        = '0;
        out_data_next[0]     = fin_reg.found;
        if (!is_put)
            out_data_next[32:1] = fin_reg.found ? fin_reg.found_val : {VAL_W{1'b1}};
        out_data_next[33]    = evict_do;
        out_data_next[65:34] = evict_do ? fin_reg.vic_key : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_W'(16);
            occ_reg       <= '0;
            clock_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                capacity_reg <= cfg_data;
            occ_reg   <= occ_next;
            clock_reg <= clock_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= s_tuser[0];
            wval_reg <= s_tdata[63:32];
        end
        if (capture)
            fin_reg <= link[ENTRIES];
        if (fire)
            out_data_reg <= out_data_next;
    end

endmodule
